// ===== design/growing_buffer_id_allocator_core_defines.svh =====
// ----------------------------------------------------------------------------
// gba assertion macros
// shared concurrent check macros for the id allocator
// ----------------------------------------------------------------------------
`ifndef GROWING_BUFFER_ID_ALLOCATOR_CORE_DEFINES_SVH
`define GROWING_BUFFER_ID_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define GBA_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gba check failed");

// next-cycle implication
`define GBA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("gba check failed");

`endif

// ===== design/gba_pkg.sv =====
// ----------------------------------------------------------------------------
// gba_pkg
// types and constants of the growing buffer id allocator
// ----------------------------------------------------------------------------
package gba_pkg;

  localparam int ID_W   = 6;
  localparam int CAP_W  = 7;
  localparam int STAT_W = 2;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

  localparam logic [APB_AW-1:0] REG_INIT_CAP = 3'd0;
  localparam logic [CAP_W-1:0]  INIT_CAP_RST = 7'd8;

  typedef struct packed {
    logic             reinit;
    logic [CAP_W-1:0] cap;
  } cfg_ctl_t;

endpackage

// ===== design/gba_cfg.sv =====
// ----------------------------------------------------------------------------
// gba_cfg
// apb register for the initial capacity and pool re-init control
// ----------------------------------------------------------------------------
module gba_cfg #(
  parameter int MAX_IDS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gba_pkg::APB_AW-1:0]   paddr,
  input  logic [gba_pkg::APB_DW-1:0]   pwdata,
  output logic [gba_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output gba_pkg::cfg_ctl_t            ctl
);
  import gba_pkg::*;

  logic [CAP_W-1:0] init_cap_r;
  logic [CAP_W-1:0] init_cap_nxt;
  logic             wr_hit;
  logic [CAP_W-1:0] clamped;

  assign pready       = 1'b1;
  assign wr_hit       = psel && penable && pwrite && (paddr == REG_INIT_CAP);
  assign init_cap_nxt = wr_hit ? pwdata[CAP_W-1:0] : init_cap_r;

  always_comb begin
    if (pwdata[CAP_W-1:0] == '0) begin
      clamped = CAP_W'(1);
    end else if (pwdata[CAP_W-1:0] > CAP_W'(MAX_IDS)) begin
      clamped = CAP_W'(MAX_IDS);
    end else begin
      clamped = pwdata[CAP_W-1:0];
    end
  end

  assign ctl.reinit = wr_hit;
  assign ctl.cap    = clamped;

  always_comb begin
    prdata = '0;
    if (paddr == REG_INIT_CAP) begin
      prdata = APB_DW'(init_cap_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cap_r <= INIT_CAP_RST;
    end else begin
      init_cap_r <= init_cap_nxt;
    end
  end

endmodule

// ===== design/gba_engine.sv =====
// ----------------------------------------------------------------------------
// gba_engine
// request register, single-pass allocate/release logic and result register
// ----------------------------------------------------------------------------
module gba_engine #(
  parameter int MAX_IDS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid,
  input  logic                         in_func,
  input  logic [gba_pkg::ID_W-1:0]     in_entry_id,
  input  gba_pkg::cfg_ctl_t            ctl,
  output logic                         out_valid,
  output logic [gba_pkg::ID_W-1:0]     out_granted_id,
  output logic                         out_granted,
  output logic [gba_pkg::STAT_W-1:0]   out_status,
  output logic [gba_pkg::CAP_W-1:0]    out_in_use_count,
  output logic [gba_pkg::CAP_W-1:0]    out_capacity_now
);
  import gba_pkg::*;

  localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam logic [CAP_W-1:0] CAP_RST =
    (int'(INIT_CAP_RST) > MAX_IDS) ? CAP_W'(MAX_IDS) : INIT_CAP_RST;

  // request stage
  logic              v_r;
  logic              func_r;
  logic [ID_W-1:0]   id_r;

  // pool state
  logic [MAX_IDS-1:0] free_r;
  logic [MAX_IDS-1:0] free_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CAP_W-1:0]   cap_nxt;
  logic [CAP_W-1:0]   used_r;
  logic [CAP_W-1:0]   used_nxt;

  // result stage
  logic              ov_r;
  logic [ID_W-1:0]   gid_r;
  logic              gnt_r;
  logic [STAT_W-1:0] stat_r;
  logic [CAP_W-1:0]  ruse_r;
  logic [CAP_W-1:0]  rcap_r;

  logic [MAX_IDS-1:0] cap_mask;
  logic [MAX_IDS-1:0] avail;
  logic [IDX_W-1:0]   low_idx;
  logic [CAP_W-1:0]   cap_dbl;
  logic [IDX_W-1:0]   gidx;
  logic               gnt;
  logic [STAT_W-1:0]  stat;
  logic [ID_W-1:0]    gid;

  always_comb begin
    for (int i = 0; i < MAX_IDS; i++) begin
      cap_mask[i] = (CAP_W'(i) < cap_r);
    end
  end

  assign avail = free_r & cap_mask;

  // lowest free id below capacity
  always_comb begin
    low_idx = '0;
    for (int i = MAX_IDS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign cap_dbl = {cap_r[CAP_W-2:0], 1'b0};

  always_comb begin
    free_nxt = free_r;
    cap_nxt  = cap_r;
    used_nxt = used_r;
    gnt      = 1'b0;
    gidx     = '0;
    stat     = ST_OK;
    if (v_r) begin
      if (func_r == FUNC_ALLOC) begin
        if (avail != '0) begin
          gnt  = 1'b1;
          gidx = low_idx;
        end else if (cap_r < CAP_W'(MAX_IDS)) begin
          // grow; ids at or above capacity are always free, so old capacity is the grant
          gnt     = 1'b1;
          gidx    = cap_r[IDX_W-1:0];
          cap_nxt = (cap_dbl > CAP_W'(MAX_IDS)) ? CAP_W'(MAX_IDS) : cap_dbl;
        end else begin
          stat = ST_EXHAUSTED;
        end
        if (gnt) begin
          free_nxt[gidx] = 1'b0;
          used_nxt       = used_r + CAP_W'(1);
        end
      end else begin
        if (CAP_W'(id_r) >= cap_r) begin
          stat = ST_RANGE;
        end else if (!free_r[id_r[IDX_W-1:0]]) begin
          free_nxt[id_r[IDX_W-1:0]] = 1'b1;
          used_nxt                  = used_r - CAP_W'(1);
        end
      end
    end
  end

  assign gid = gnt ? ID_W'(gidx) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      ov_r   <= 1'b0;
      free_r <= '1;
      cap_r  <= CAP_RST;
      used_r <= '0;
    end else begin
      v_r  <= req_valid;
      ov_r <= v_r;
      if (ctl.reinit) begin
        free_r <= '1;
        cap_r  <= ctl.cap;
        used_r <= '0;
      end else begin
        free_r <= free_nxt;
        cap_r  <= cap_nxt;
        used_r <= used_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      func_r <= in_func;
      id_r   <= in_entry_id;
    end
    if (v_r) begin
      gid_r  <= gid;
      gnt_r  <= gnt;
      stat_r <= stat;
      ruse_r <= used_nxt;
      rcap_r <= cap_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_granted_id   = gid_r;
  assign out_granted      = gnt_r;
  assign out_status       = stat_r;
  assign out_in_use_count = ruse_r;
  assign out_capacity_now = rcap_r;

endmodule

// ===== design/growing_buffer_id_allocator_core.sv =====
// ----------------------------------------------------------------------------
// growing_buffer_id_allocator_core
// lowest-free-id bitmap allocator with a capacity that doubles on demand
// ----------------------------------------------------------------------------
// usage:
//   request channel: pulse start with in_func (0 allocate, 1 release) and
//   in_entry_id; busy is always low, so a request beat is taken every cycle.
//   result channel: out_valid marks one cycle carrying out_granted_id,
//   out_granted, out_status, out_in_use_count and out_capacity_now.
//   path: each request goes through one request register, then one result
//   register, before its result beat is on the ports; throughput is one
//   request per cycle, set by the combinational priority encoder over the
//   free map.
//   the receiver cannot stall: each result is shown for exactly one cycle.
//   configuration: apb register 0 (byte address 0) holds initial_capacity;
//   a write re-initializes the pool (all ids free, capacity clamped to
//   1..MAX_IDS). write it only with no request in flight.
//   reset: synchronous active-low rst_n frees all ids and sets the capacity
//   to 8 (clamped to MAX_IDS); no clearing pass is needed.
// ----------------------------------------------------------------------------
module growing_buffer_id_allocator_core #(
  parameter int MAX_IDS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_func,
  input  logic [gba_pkg::ID_W-1:0]     in_entry_id,
  output logic                         out_valid,
  output logic [gba_pkg::ID_W-1:0]     out_granted_id,
  output logic                         out_granted,
  output logic [gba_pkg::STAT_W-1:0]   out_status,
  output logic [gba_pkg::CAP_W-1:0]    out_in_use_count,
  output logic [gba_pkg::CAP_W-1:0]    out_capacity_now,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gba_pkg::APB_AW-1:0]   paddr,
  input  logic [gba_pkg::APB_DW-1:0]   pwdata,
  output logic [gba_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import gba_pkg::*;

  `include "growing_buffer_id_allocator_core_defines.svh"

  cfg_ctl_t ctl;
  logic     req_valid;

  assign busy      = 1'b0;
  assign req_valid = start && !busy;

  gba_cfg #(
    .MAX_IDS (MAX_IDS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  gba_engine #(
    .MAX_IDS (MAX_IDS)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req_valid),
    .in_func          (in_func),
    .in_entry_id      (in_entry_id),
    .ctl              (ctl),
    .out_valid        (out_valid),
    .out_granted_id   (out_granted_id),
    .out_granted      (out_granted),
    .out_status       (out_status),
    .out_in_use_count (out_in_use_count),
    .out_capacity_now (out_capacity_now)
  );

  `GBA_ASSERT_NEXT(a_result_latency, req_valid, ##1 out_valid)
  `GBA_ASSERT_NOW(a_grant_ok, out_valid && out_granted, out_status == ST_OK)
  `GBA_ASSERT_NOW(a_use_le_cap, out_valid, out_in_use_count <= out_capacity_now)
  `GBA_ASSERT_NOW(a_nogrant_zero, out_valid && !out_granted, out_granted_id == '0)

endmodule
